FILE: src/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/uart_pkg.sv
// types and constants of the uart register block
package uart_pkg;
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_RX    = 2'd2,
    OP_TXRDY = 2'd3
  } op_t;

  localparam logic [2:0] OFF_DATA = 3'd0;
  localparam logic [2:0] OFF_IER  = 3'd1;
  localparam logic [2:0] OFF_IIR  = 3'd2;
  localparam logic [2:0] OFF_LCR  = 3'd3;
  localparam logic [2:0] OFF_MCR  = 3'd4;
  localparam logic [2:0] OFF_LSR  = 3'd5;
  localparam logic [2:0] OFF_MSR  = 3'd6;
  localparam logic [2:0] OFF_SCR  = 3'd7;

  localparam logic [7:0] RX_EMPTY_BYTE = 8'h60;
  localparam logic [7:0] DIV_LOW_RST   = 8'd12;
  localparam logic [7:0] LCR_RST       = 8'd3;
  localparam logic [4:0] TRIG_4        = 5'd4;
  localparam logic [4:0] TRIG_8        = 5'd8;
  localparam logic [4:0] TRIG_14       = 5'd14;
  localparam logic [4:0] TRIG_1        = 5'd1;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } result_t;

  // selects the byte that the result takes from a memory read
  typedef struct packed {
    logic use_rx;
    logic use_tx;
  } mem_sel_t;
endpackage

FILE: src/uart_ram.sv
// byte ring buffer storage, one write and one registered read port
module uart_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: src/uart_16550_register_model.sv
// top level of the 16550-style uart register block
//
// one input channel carries bus reads, bus writes, line bytes received and
// line-ready requests; every input transaction gives exactly one result
// transaction with read data, the irq level, and a byte for the line.
// all registers and ring pointers are updated in the cycle a transaction
// is accepted, so a new transaction may be taken every cycle. a result
// leaves from the output register, after the synchronous read of the
// receive or transmit buffer memory has returned its byte. the
// throughput is one transaction per cycle while the receiver takes them.
// when out_tready is low the output register holds and in_tready drops
// once the stage behind it is full, so nothing is lost.
// reset clears pointers, counts and registers to their power-up values;
// buffer contents are left as they are and are read only once written.
// BUF_DEPTH sets the size of each ring buffer.
module uart_16550_register_model #(
  parameter int BUF_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // op[1:0], offset[4:2], wdata[12:5], rx_byte[20:13]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // rdata[7:0], irq[8], tx_valid[9], tx_byte[17:10]
);
  import uart_pkg::*;
  `include "assert_macros.svh"

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(BUF_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(BUF_DEPTH - 1);

  logic [1:0] op;
  logic [2:0] off;
  logic [7:0] wd, rxb;
  assign op  = in_tdata[1:0];
  assign off = in_tdata[4:2];
  assign wd  = in_tdata[12:5];
  assign rxb = in_tdata[20:13];

  logic [AW-1:0] rx_head_r, tx_head_r;
  logic [CW-1:0] rx_count_r, tx_count_r;
  logic [7:0] dll_r, dlm_r, ier_r, fcr_r, lcr_r, mcr_r, msr_r, scr_r;
  logic tep_r;

  logic [AW-1:0] rx_head_nxt, tx_head_nxt;
  logic [CW-1:0] rx_count_nxt, tx_count_nxt;
  logic [7:0] dll_nxt, dlm_nxt, ier_nxt, fcr_nxt, lcr_nxt, mcr_nxt, msr_nxt, scr_nxt;
  logic tep_nxt;

  // stage 1: memory read in flight, stage 2: output register
  logic       s1_v_r, s2_v_r;
  result_t    s1_res_r, s1_res_nxt, s2_res_r, s2_res_nxt;
  mem_sel_t   s1_sel_r, s1_sel_nxt;
  logic       s1_adv, acc;

  logic          rx_we, tx_we, rx_re, tx_re;
  logic [AW-1:0] rx_waddr, tx_waddr;
  logic [7:0]    rx_rd, tx_rd;

  assign s1_adv    = !s2_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_adv;
  assign acc       = in_tvalid && in_tready;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, CW'(a)} + {1'b0, b};
    if (s >= (CW+1)'(BUF_DEPTH)) begin
      s = s - (CW+1)'(BUF_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  logic dlab, rx_ne, tx_ne;
  logic [4:0] trig;
  logic [7:0] iir, lsr;
  assign dlab  = lcr_r[7];
  assign rx_ne = rx_count_r != '0;
  assign tx_ne = tx_count_r != '0;

  always_comb begin
    trig = TRIG_1;
    if (fcr_r[0]) begin
      case (fcr_r[7:6])
        2'd1:    trig = TRIG_4;
        2'd2:    trig = TRIG_8;
        2'd3:    trig = TRIG_14;
        default: trig = TRIG_1;
      endcase
    end
    iir = fcr_r[0] ? 8'hC1 : 8'h01;
    if (ier_r[0] && rx_ne) begin
      iir = {iir[7:1], 1'b0} | ((rx_count_r >= CW'(trig)) ? 8'h04 : 8'h0C);
    end else if (ier_r[1] && tep_r) begin
      iir = {iir[7:1], 1'b0} | 8'h02;
    end
    lsr = {1'b0, !tx_ne, tx_count_r != FULL, 4'b0, rx_ne};
  end

  always_comb begin
    rx_head_nxt = rx_head_r; rx_count_nxt = rx_count_r;
    tx_head_nxt = tx_head_r; tx_count_nxt = tx_count_r;
    dll_nxt = dll_r; dlm_nxt = dlm_r; ier_nxt = ier_r; fcr_nxt = fcr_r;
    lcr_nxt = lcr_r; mcr_nxt = mcr_r; msr_nxt = msr_r; scr_nxt = scr_r;
    tep_nxt = tep_r;
    s1_res_nxt = '0;
    s1_sel_nxt = '0;
    rx_we = 1'b0; tx_we = 1'b0; rx_re = 1'b0; tx_re = 1'b0;
    rx_waddr = wrap(rx_head_r, rx_count_r);
    tx_waddr = wrap(tx_head_r, tx_count_r);
    if (acc) begin
      case (op)
        OP_READ: begin
          case (off)
            OFF_DATA: begin
              if (dlab) begin
                s1_res_nxt.rdata = dll_r;
              end else if (rx_ne) begin
                rx_re = 1'b1;
                s1_sel_nxt.use_rx = 1'b1;
                rx_head_nxt = (rx_head_r == LAST) ? '0 : rx_head_r + 1'b1;
                rx_count_nxt = rx_count_r - 1'b1;
              end else begin
                s1_res_nxt.rdata = RX_EMPTY_BYTE;
              end
            end
            OFF_IER: s1_res_nxt.rdata = dlab ? dlm_r : ier_r;
            OFF_IIR: begin
              s1_res_nxt.rdata = iir;
              if (!(ier_r[0] && rx_ne) && ier_r[1]) begin
                tep_nxt = 1'b0;
              end
            end
            OFF_LCR: s1_res_nxt.rdata = lcr_r;
            OFF_MCR: s1_res_nxt.rdata = mcr_r;
            OFF_LSR: s1_res_nxt.rdata = lsr;
            OFF_MSR: s1_res_nxt.rdata = msr_r | 8'hB0;
            default: s1_res_nxt.rdata = scr_r;
          endcase
        end
        OP_WRITE: begin
          case (off)
            OFF_DATA: begin
              if (dlab) begin
                dll_nxt = wd;
              end else begin
                tep_nxt = 1'b0;
                if (tx_count_r != FULL) begin
                  tx_we = 1'b1;
                  tx_count_nxt = tx_count_r + 1'b1;
                end
              end
            end
            OFF_IER: begin
              if (dlab) begin
                dlm_nxt = wd;
              end else begin
                ier_nxt = wd;
                if (wd[1] && !tx_ne) begin
                  tep_nxt = 1'b1;
                end
              end
            end
            OFF_IIR: begin
              fcr_nxt = wd & 8'hC1;
              if (wd[1]) begin
                rx_count_nxt = '0;
              end
              if (wd[2]) begin
                tx_count_nxt = '0;
                tep_nxt = 1'b1;
              end
            end
            OFF_LCR: lcr_nxt = wd;
            OFF_MCR: mcr_nxt = wd;
            OFF_LSR: ;
            OFF_MSR: msr_nxt = wd;
            default: scr_nxt = wd;
          endcase
        end
        OP_RX: begin
          if (rx_count_r != FULL) begin
            rx_we = 1'b1;
            rx_count_nxt = rx_count_r + 1'b1;
          end
        end
        default: begin
          if (tx_ne) begin
            tx_re = 1'b1;
            s1_sel_nxt.use_tx = 1'b1;
            s1_res_nxt.tx_valid = 1'b1;
            tx_head_nxt = (tx_head_r == LAST) ? '0 : tx_head_r + 1'b1;
            tx_count_nxt = tx_count_r - 1'b1;
            if (tx_count_r == CW'(1) && ier_r[1]) begin
              tep_nxt = 1'b1;
            end
          end
        end
      endcase
      s1_res_nxt.irq = (ier_nxt[0] && rx_count_nxt != '0) || (ier_nxt[1] && tep_nxt);
    end
  end

  // a write and a read never hit the same entry: reads take only filled entries
  uart_ram #(.DEPTH(BUF_DEPTH), .AW(AW)) u_rx_ram (
    .clk(clk), .we(rx_we), .waddr(rx_waddr), .wdata(rxb),
    .re(rx_re), .raddr(rx_head_r), .rdata(rx_rd)
  );
  uart_ram #(.DEPTH(BUF_DEPTH), .AW(AW)) u_tx_ram (
    .clk(clk), .we(tx_we), .waddr(tx_waddr), .wdata(wd),
    .re(tx_re), .raddr(tx_head_r), .rdata(tx_rd)
  );

  always_comb begin
    s2_res_nxt = s1_res_r;
    if (s1_sel_r.use_rx) begin
      s2_res_nxt.rdata = rx_rd;
    end
    if (s1_sel_r.use_tx) begin
      s2_res_nxt.tx_byte = tx_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r <= '0; rx_count_r <= '0; tx_head_r <= '0; tx_count_r <= '0;
      dll_r <= DIV_LOW_RST; dlm_r <= '0; ier_r <= '0; fcr_r <= '0;
      lcr_r <= LCR_RST; mcr_r <= '0; msr_r <= '0; scr_r <= '0;
      tep_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      rx_head_r <= rx_head_nxt; rx_count_r <= rx_count_nxt;
      tx_head_r <= tx_head_nxt; tx_count_r <= tx_count_nxt;
      dll_r <= dll_nxt; dlm_r <= dlm_nxt; ier_r <= ier_nxt; fcr_r <= fcr_nxt;
      lcr_r <= lcr_nxt; mcr_r <= mcr_nxt; msr_r <= msr_nxt; scr_r <= scr_nxt;
      tep_r <= tep_nxt;
      if (in_tready) begin
        s1_v_r <= acc;
      end
      if (s1_adv) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  // stage 1 payload only moves with the pipeline, so the memory data stays aligned
  always_ff @(posedge clk) begin
    if (in_tready) begin
      s1_res_r <= s1_res_nxt;
      s1_sel_r <= s1_sel_nxt;
    end
    if (s1_adv && s1_v_r) begin
      s2_res_r <= s2_res_nxt;
    end
  end

  assign out_tvalid = s2_v_r;
  assign out_tdata  = {6'b0, s2_res_r.tx_byte, s2_res_r.tx_valid, s2_res_r.irq,
                       s2_res_r.rdata};

  `ASSERT_IMP(a_rx_count_range, clk, rst_n, 1'b1, rx_count_r <= FULL)
  `ASSERT_IMP(a_tx_count_range, clk, rst_n, 1'b1, tx_count_r <= FULL)
  `ASSERT_NEXT(a_stall_holds, clk, rst_n, out_tvalid && !out_tready,
               out_tvalid && $stable(out_tdata))
  `ASSERT_IMP(a_one_sel, clk, rst_n, s1_v_r, !(s1_sel_r.use_rx && s1_sel_r.use_tx))
endmodule

FILE: sim/tb_top.sv
// testbench of the uart register block: queued driver, clocked monitor, predictor scoreboard
`timescale 1ns / 1ps
module tb_top;
  import uart_pkg::*;

  localparam int DEPTH = 1024;

  // last field in the lowest bits, matching the in_tdata layout
  typedef struct packed {
    logic [7:0] rx_byte;
    logic [7:0] wdata;
    logic [2:0] offset;
    logic [1:0] op;
  } uart_txn_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [23:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [23:0] out_tdata;

  uart_16550_register_model #(.BUF_DEPTH(DEPTH)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // predictor state
  logic [7:0] rx_ring[DEPTH];
  logic [7:0] tx_ring[DEPTH];
  int unsigned rx_rd, rx_cnt, tx_rd, tx_cnt;
  logic [7:0] div_lo, div_hi, ier, fcr, lcr, mcr, msr, scr;
  logic thre_pend;

  uart_txn_t pending_items[$];
  result_t expected_results[$];
  int errors;
  int idle_pct, stall_pct;
  int hold_cycles;

  task automatic report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("mismatch %s: got %02h expected %02h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic int unsigned trigger_level();
    if (!fcr[0]) return 1;
    case (fcr[7:6])
      2'd1: return 4;
      2'd2: return 8;
      2'd3: return 14;
      default: return 1;
    endcase
  endfunction

  function automatic logic [7:0] bus_read_value(input logic [2:0] off);
    logic [7:0] v;
    logic dlab;
    dlab = lcr[7];
    v = 8'h00;
    case (off)
      OFF_DATA: begin
        if (dlab) v = div_lo;
        else if (rx_cnt > 0) begin
          v = rx_ring[rx_rd];
          rx_rd = (rx_rd + 1) % DEPTH;
          rx_cnt--;
        end else v = RX_EMPTY_BYTE;
      end
      OFF_IER: v = dlab ? div_hi : ier;
      OFF_IIR: begin
        v = fcr[0] ? 8'hC1 : 8'h01;
        if (ier[0] && rx_cnt > 0)
          v = (v & 8'hFE) | ((rx_cnt >= trigger_level()) ? 8'h04 : 8'h0C);
        else if (ier[1] && thre_pend) begin
          thre_pend = 1'b0;
          v = (v & 8'hFE) | 8'h02;
        end
      end
      OFF_LCR: v = lcr;
      OFF_MCR: v = mcr;
      OFF_LSR: begin
        v = 8'h60;
        if (rx_cnt > 0) v[0] = 1'b1;
        if (tx_cnt > 0) begin
          v[6] = 1'b0;
          if (tx_cnt >= DEPTH) v[5] = 1'b0;
        end
      end
      OFF_MSR: v = msr | 8'hB0;
      default: v = scr;
    endcase
    return v;
  endfunction

  function automatic void bus_write_value(input logic [2:0] off, input logic [7:0] val);
    logic dlab;
    dlab = lcr[7];
    case (off)
      OFF_DATA: begin
        if (dlab) div_lo = val;
        else begin
          thre_pend = 1'b0;
          if (tx_cnt < DEPTH) begin
            tx_ring[(tx_rd + tx_cnt) % DEPTH] = val;
            tx_cnt++;
          end
        end
      end
      OFF_IER: begin
        if (dlab) div_hi = val;
        else begin
          ier = val;
          if (val[1] && tx_cnt == 0) thre_pend = 1'b1;
        end
      end
      OFF_IIR: begin
        fcr = val & 8'hC1;
        if (val[1]) rx_cnt = 0;
        if (val[2]) begin
          tx_cnt = 0;
          thre_pend = 1'b1;
        end
      end
      OFF_LCR: lcr = val;
      OFF_MCR: mcr = val;
      OFF_LSR: ;
      OFF_MSR: msr = val;
      default: scr = val;
    endcase
  endfunction

  function automatic result_t predict_uart(input uart_txn_t t);
    result_t r;
    r = '0;
    case (op_t'(t.op))
      OP_READ: r.rdata = bus_read_value(t.offset);
      OP_WRITE: bus_write_value(t.offset, t.wdata);
      OP_RX: begin
        if (rx_cnt < DEPTH) begin
          rx_ring[(rx_rd + rx_cnt) % DEPTH] = t.rx_byte;
          rx_cnt++;
        end
      end
      default: begin
        if (tx_cnt > 0) begin
          r.tx_byte = tx_ring[tx_rd];
          r.tx_valid = 1'b1;
          tx_rd = (tx_rd + 1) % DEPTH;
          tx_cnt--;
          if (tx_cnt == 0 && ier[1]) thre_pend = 1'b1;
        end
      end
    endcase
    r.irq = (ier[0] && rx_cnt > 0) || (ier[1] && thre_pend);
    return r;
  endfunction

  function automatic uart_txn_t make_item(input op_t op, input logic [2:0] off,
                                          input logic [7:0] wd, input logic [7:0] rb);
    uart_txn_t t;
    t.op = op;
    t.offset = off;
    t.wdata = wd;
    t.rx_byte = rb;
    return t;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) void'(pending_items.pop_front());
      if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= {3'b000, pending_items[0]};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // predictor runs on accepted input transactions
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      expected_results.push_back(predict_uart(uart_txn_t'(in_tdata[20:0])));
  end

  // receiver readiness
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.rdata    = out_tdata[7:0];
      got.irq      = out_tdata[8];
      got.tx_valid = out_tdata[9];
      got.tx_byte  = out_tdata[17:10];
      if (expected_results.size() == 0) begin
        $display("unexpected result transaction %05h at %0t", out_tdata, $time);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.rdata !== want.rdata) report_mismatch("rdata", got.rdata, want.rdata);
        if (got.irq !== want.irq) report_mismatch("irq", got.irq, want.irq);
        if (got.tx_valid !== want.tx_valid)
          report_mismatch("tx_valid", got.tx_valid, want.tx_valid);
        if (got.tx_byte !== want.tx_byte) report_mismatch("tx_byte", got.tx_byte, want.tx_byte);
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  // random item: mostly data traffic that exercises both rings and the iir
  function automatic uart_txn_t random_item();
    int k;
    logic [2:0] off;
    logic [7:0] wd;
    logic [7:0] rb;
    k = $urandom_range(99);
    off = 3'($urandom_range(7));
    wd = 8'($urandom_range(255));
    rb = 8'($urandom_range(255));
    if (k < 25) return make_item(OP_RX, off, wd, rb);
    if (k < 45) return make_item(OP_TXRDY, off, wd, rb);
    if (k < 60) return make_item(OP_READ, OFF_DATA, wd, rb);
    if (k < 72) return make_item(OP_WRITE, OFF_DATA, wd, rb);
    if (k < 80) return make_item(OP_READ, $urandom_range(1) ? OFF_IIR : OFF_LSR, wd, 8'h00);
    if (k < 84) return make_item(OP_WRITE, OFF_IER, wd, 8'h00);
    if (k < 87) begin
      // lcr writes keep dlab mostly clear
      if ($urandom_range(3) != 0) wd[7] = 1'b0;
      return make_item(OP_WRITE, OFF_LCR, wd, 8'h00);
    end
    if (k < 90) begin
      // avoid emptying the fifos too often
      if ($urandom_range(3) != 0) wd[2:1] = 2'b00;
      return make_item(OP_WRITE, OFF_IIR, wd, 8'h00);
    end
    if (k < 95) return make_item(OP_READ, off, wd, rb);
    return make_item(OP_WRITE, off == OFF_LCR ? OFF_SCR : off, wd, rb);
  endfunction

  initial begin
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    rx_rd = 0; rx_cnt = 0; tx_rd = 0; tx_cnt = 0;
    div_lo = DIV_LOW_RST; div_hi = 8'h00; lcr = LCR_RST;
    ier = 8'h00; fcr = 8'h00; mcr = 8'h00; msr = 8'h00; scr = 8'h00;
    thre_pend = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset values, empty reads, extremes, dlab, trigger levels
    for (int o = 0; o < 8; o++)
      pending_items.push_back(make_item(OP_READ, 3'(o), 8'h00, 8'h00));
    pending_items.push_back(make_item(OP_TXRDY, 3'd0, 8'hFF, 8'hFF));
    pending_items.push_back(make_item(OP_WRITE, OFF_IER, 8'hFF, 8'h00));
    pending_items.push_back(make_item(OP_READ, OFF_IIR, 8'h00, 8'h00));
    pending_items.push_back(make_item(OP_WRITE, OFF_DATA, 8'hFF, 8'h00));
    pending_items.push_back(make_item(OP_WRITE, OFF_DATA, 8'h00, 8'h00));
    pending_items.push_back(make_item(OP_RX, 3'd7, 8'h00, 8'hFF));
    pending_items.push_back(make_item(OP_RX, 3'd0, 8'hFF, 8'h00));
    pending_items.push_back(make_item(OP_WRITE, OFF_IIR, 8'hC1, 8'h00));
    pending_items.push_back(make_item(OP_READ, OFF_IIR, 8'h00, 8'h00));
    pending_items.push_back(make_item(OP_WRITE, OFF_LSR, 8'hFF, 8'h00));
    pending_items.push_back(make_item(OP_WRITE, OFF_MSR, 8'hFF, 8'h00));
    pending_items.push_back(make_item(OP_WRITE, OFF_LCR, 8'hFF, 8'h00));
    pending_items.push_back(make_item(OP_WRITE, OFF_DATA, 8'hA5, 8'h00));
    pending_items.push_back(make_item(OP_WRITE, OFF_IER, 8'h5A, 8'h00));
    pending_items.push_back(make_item(OP_READ, OFF_DATA, 8'h00, 8'h00));
    pending_items.push_back(make_item(OP_READ, OFF_IER, 8'h00, 8'h00));
    pending_items.push_back(make_item(OP_WRITE, OFF_LCR, 8'h03, 8'h00));
    pending_items.push_back(make_item(OP_WRITE, OFF_IIR, 8'h07, 8'h00));
    pending_items.push_back(make_item(OP_TXRDY, 3'd0, 8'h00, 8'h00));
    pending_items.push_back(make_item(OP_READ, OFF_LSR, 8'h00, 8'h00));
    wait_drained();

    // fill the receive ring to full and overflow it, with the receiver held off at the start
    hold_cycles = 300;
    for (int i = 0; i < DEPTH + 2; i++)
      pending_items.push_back(make_item(OP_RX, 3'd0, 8'h00, 8'($urandom_range(255))));
    pending_items.push_back(make_item(OP_READ, OFF_LSR, 8'h00, 8'h00));
    for (int i = 0; i < 3; i++)
      pending_items.push_back(make_item(OP_READ, OFF_DATA, 8'h00, 8'h00));
    // flush both rings
    pending_items.push_back(make_item(OP_WRITE, OFF_IIR, 8'h07, 8'h00));
    pending_items.push_back(make_item(OP_READ, OFF_LSR, 8'h00, 8'h00));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 50 : 28) : 0;
      stall_pct = (ph == 2) ? 50 : (ph == 3 ? 28 : 0);
      for (int i = 0; i < 40; i++) pending_items.push_back(random_item());
      wait_drained();
    end
    repeat (10) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
